### rtl/mm2a_pkg.sv
// Shared types and constants for the byte-stream MurmurHash2A block.
`default_nettype none

package mm2a_pkg;

    // Murmur multiplier and shift amounts.
    localparam logic [31:0] MURMUR_MUL   = 32'h5bd1e995;
    localparam int unsigned MURMUR_SHIFT = 24;
    localparam int unsigned FIN_SHIFT_A  = 13;
    localparam int unsigned FIN_SHIFT_B  = 15;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_H,
        ST_TAIL,
        ST_LEN,
        ST_FIN,
        ST_FOUT
    } mm2a_state_t;

    // Which value the current fold is mixing in.
    typedef enum logic [1:0] {
        FOLD_DATA,
        FOLD_TAIL,
        FOLD_LEN
    } mm2a_fold_t;

endpackage

`default_nettype wire

### rtl/murmur2a_byte_stream_hash32.sv
// Byte-stream MurmurHash2A (32-bit) with one shared multiplier under a small sequencer.
//
// Usage: one key byte per input word on the in_valid / in_stall channel, with
// first_of_key loading seed into the running hash and last_of_key closing the key.
// An empty key is one word with first_of_key and last_of_key set and byte_valid low.
// Each closed key yields one word on the out_valid / out_stall channel carrying
// hash_value; other input words yield nothing.
// Sequencing: all multiplications run one after another through a single 32x32
// multiplier, one per cycle. A byte that does not complete a group of four needs
// only the accept; a byte that completes a group is accepted and then passes
// through three multiplies. The last word of a key, after any group that it
// completes, then runs the tail fold, length fold and finalizer, after which the
// hash sits in the output register.
// in_stall is high whenever the sequencer is busy with a word.
// If the receiver holds out_stall, the finished hash stays in the output register;
// the block still takes further words and only waits when a second hash is ready
// before the first one has been taken.
// Reset clears the running hash, pending bytes, length and the output valid.
`default_nettype none

module murmur2a_byte_stream_hash32
    import mm2a_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  key_byte,
    input  wire logic        byte_valid,
    input  wire logic        first_of_key,
    input  wire logic        last_of_key,
    input  wire logic [31:0] seed,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      hash_value
);

    mm2a_state_t state_reg, state_next;
    mm2a_fold_t  fold_reg, fold_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] acc_reg, acc_next;
    logic [23:0] pend_reg, pend_next;
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] len_reg, len_next;
    logic        last_reg, last_next;
    logic        oval_reg, oval_next;
    logic [31:0] out_reg, out_next;

    logic [31:0] base_hash;
    logic [23:0] base_pend;
    logic [1:0]  base_phase;
    logic [31:0] base_len;
    logic [31:0] tail_word;
    logic [31:0] mul_op;
    logic [31:0] mul_res;
    logic        accept;
    logic        out_free;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = oval_reg;
    assign hash_value = out_reg;
    assign out_free  = !oval_reg || !out_stall;

    // State seen by an accepted word after an optional seed load.
    assign base_hash  = first_of_key ? seed : hash_reg;
    assign base_pend  = first_of_key ? 24'd0 : pend_reg;
    assign base_phase = first_of_key ? 2'd0 : phase_reg;
    assign base_len   = first_of_key ? 32'd0 : len_reg;

    // Leftover bytes repacked little-endian; the earliest byte goes lowest.
    always_comb
    begin
        case (phase_reg)
            2'd1: tail_word = {24'd0, pend_reg[7:0]};
            2'd2: tail_word = {16'd0, pend_reg[7:0], pend_reg[15:8]};
            2'd3: tail_word = {8'd0, pend_reg[7:0], pend_reg[15:8], pend_reg[23:16]};
            default: tail_word = 32'd0;
        endcase
    end

    // Operand select for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            ST_K1:   mul_op = acc_reg;
            ST_K2:   mul_op = acc_reg ^ (acc_reg >> MURMUR_SHIFT);
            ST_H:    mul_op = hash_reg;
            ST_TAIL: mul_op = tail_word;
            ST_LEN:  mul_op = len_reg;
            ST_FIN:  mul_op = hash_reg ^ (hash_reg >> FIN_SHIFT_A);
            default: mul_op = acc_reg;
        endcase
    end

    // The one multiplier; only the low 32 bits of the product are kept.
    assign mul_res = mul_op * MURMUR_MUL;

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next = state_reg;
        fold_next  = fold_reg;
        hash_next  = hash_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        phase_next = phase_reg;
        len_next   = len_reg;
        last_next  = last_reg;
        oval_next  = oval_reg;
        out_next   = out_reg;

        if (oval_reg && !out_stall)
        begin
            oval_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hash_next  = base_hash;
                    pend_next  = base_pend;
                    phase_next = base_phase;
                    len_next   = base_len;
                    last_next  = last_of_key;
                    fold_next  = FOLD_DATA;
                    if (byte_valid)
                    begin
                        len_next = base_len + 32'd1;
                        if (base_phase == 2'd3)
                        begin
                            acc_next   = {base_pend, key_byte};
                            pend_next  = 24'd0;
                            phase_next = 2'd0;
                        end
                        else
                        begin
                            pend_next  = {base_pend[15:0], key_byte};
                            phase_next = base_phase + 2'd1;
                        end
                    end
                    if (byte_valid && (base_phase == 2'd3))
                    begin
                        state_next = ST_K1;
                    end
                    else if (last_of_key)
                    begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_K1:
            begin
                acc_next   = mul_res;
                state_next = ST_K2;
            end
            ST_K2:
            begin
                acc_next   = mul_res;
                state_next = ST_H;
            end
            ST_H:
            begin
                hash_next = mul_res ^ acc_reg;
                case (fold_reg)
                    FOLD_DATA: state_next = last_reg ? ST_TAIL : ST_IDLE;
                    FOLD_TAIL: state_next = ST_LEN;
                    FOLD_LEN:  state_next = ST_FIN;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_TAIL:
            begin
                acc_next   = mul_res;
                fold_next  = FOLD_TAIL;
                state_next = ST_K2;
            end
            ST_LEN:
            begin
                acc_next   = mul_res;
                fold_next  = FOLD_LEN;
                state_next = ST_K2;
            end
            ST_FIN:
            begin
                hash_next  = mul_res;
                state_next = ST_FOUT;
            end
            ST_FOUT:
            begin
                // Hand the hash over once the output register is free.
                if (out_free)
                begin
                    hash_next  = hash_reg ^ (hash_reg >> FIN_SHIFT_B);
                    out_next   = hash_reg ^ (hash_reg >> FIN_SHIFT_B);
                    oval_next  = 1'b1;
                    pend_next  = 24'd0;
                    phase_next = 2'd0;
                    len_next   = 32'd0;
                    last_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and hash state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fold_reg  <= FOLD_DATA;
            hash_reg  <= 32'd0;
            pend_reg  <= 24'd0;
            phase_reg <= 2'd0;
            len_reg   <= 32'd0;
            last_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fold_reg  <= fold_next;
            hash_reg  <= hash_next;
            pend_reg  <= pend_next;
            phase_reg <= phase_next;
            len_reg   <= len_next;
            last_reg  <= last_next;
            oval_reg  <= oval_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

### tb/murmur2a_byte_stream_hash32_test.sv
// Self-checking testbench for the byte-stream MurmurHash2A block.
`timescale 1ns / 100ps

module murmur2a_byte_stream_hash32_test
    import mm2a_pkg::*;
();

    localparam int RANDOM_WORDS   = 1430;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 30;

    // Tracks the running hash of the current key and the hashes still owed.
    class key_hash_tracker;
        bit [31:0] run_hash;
        bit [23:0] held_bytes;
        bit [1:0]  held_count;
        bit [31:0] byte_total;
        bit [31:0] expected_hashes[$];
        int        fails;

        function new();
            run_hash   = '0;
            held_bytes = '0;
            held_count = '0;
            byte_total = '0;
            fails      = 0;
        endfunction

        // One Murmur mix step of value k into hash h.
        function bit [31:0] mm_fold(bit [31:0] h, bit [31:0] k);
            bit [31:0] m;
            m = k * MURMUR_MUL;
            m = m ^ (m >> MURMUR_SHIFT);
            m = m * MURMUR_MUL;
            return (h * MURMUR_MUL) ^ m;
        endfunction

        // Applies one accepted input word to the running state.
        function void note_word(bit [7:0] kb, bit bv, bit fk, bit lk, bit [31:0] sd);
            bit [31:0] tail;
            bit [31:0] h;
            int        n;
            if (fk)
            begin
                run_hash   = sd;
                held_bytes = '0;
                held_count = '0;
                byte_total = '0;
            end
            if (bv)
            begin
                byte_total = byte_total + 1;
                if (held_count == 2'd3)
                begin
                    // A full group is read with the earliest byte on top.
                    run_hash   = mm_fold(run_hash, {held_bytes, kb});
                    held_bytes = '0;
                    held_count = '0;
                end
                else
                begin
                    held_bytes = {held_bytes[15:0], kb};
                    held_count = held_count + 2'd1;
                end
            end
            if (lk)
            begin
                // Leftover bytes go into the tail with the earliest byte lowest.
                tail = '0;
                n = int'(held_count);
                for (int i = 0; i < n; i++)
                    tail[8*i +: 8] = held_bytes[8*(n-1-i) +: 8];
                h = mm_fold(run_hash, tail);
                h = mm_fold(h, byte_total);
                h = h ^ (h >> FIN_SHIFT_A);
                h = h * MURMUR_MUL;
                h = h ^ (h >> FIN_SHIFT_B);
                run_hash   = h;
                held_bytes = '0;
                held_count = '0;
                byte_total = '0;
                expected_hashes.push_back(h);
            end
        endfunction

        // Compares one delivered hash with the oldest one owed.
        function void check_hash(bit [31:0] got);
            bit [31:0] want;
            if (expected_hashes.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("ERROR: unexpected hash %08h at %0t", got, $realtime);
            end
            else
            begin
                want = expected_hashes.pop_front();
                if (want !== got)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("ERROR: hash_value expected %08h actual %08h at %0t",
                                 want, got, $realtime);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  key_byte;
    logic        byte_valid;
    logic        first_of_key;
    logic        last_of_key;
    logic [31:0] seed;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] hash_value;

    key_hash_tracker tracker;
    int word_count;
    int burst_left;
    int stall_mode;
    int stall_run;
    int idle_cycles;

    murmur2a_byte_stream_hash32 u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .key_byte     (key_byte),
        .byte_valid   (byte_valid),
        .first_of_key (first_of_key),
        .last_of_key  (last_of_key),
        .seed         (seed),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hash_value   (hash_value)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Presents one word and holds it until the block takes it.
    task automatic send_word(input bit [7:0] kb, input bit bv, input bit fk, input bit lk,
                             input bit [31:0] sd);
        begin
            @(negedge clk);
            key_byte     <= kb;
            byte_valid   <= bv;
            first_of_key <= fk;
            last_of_key  <= lk;
            seed         <= sd;
            in_valid     <= 1'b1;
            do
                @(posedge clk);
            while (in_stall);
            tracker.note_word(kb, bv, fk, lk, sd);
            if (bv || fk || lk)
                word_count++;
        end
    endtask

    // Sender pacing: bursts of random length, separated by random gaps.
    task automatic pace();
        int gap;
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
            burst_left--;
        end
    endtask

    // Sends one key; the flavor picks how the sequence is shaped or broken.
    task automatic send_key(input int len, input bit [31:0] sd, input int flavor);
        bit with_first;
        bit invalid_end;
        int restart_at;
        begin
            with_first  = (flavor >= 8);
            invalid_end = (flavor >= 21 && flavor < 28);
            restart_at  = (flavor >= 16 && flavor < 21 && len > 1) ?
                          $urandom_range(1, len - 1) : -1;
            if (len == 0)
            begin
                pace();
                send_word(8'($urandom), 1'b0, with_first, 1'b1, sd);
            end
            else
            begin
                for (int i = 0; i < len; i++)
                begin
                    // Some keys carry ignored words between their bytes.
                    if (flavor >= 8 && flavor < 16 && $urandom_range(3) == 0)
                    begin
                        pace();
                        send_word(8'($urandom), 1'b0, 1'b0, 1'b0, $urandom);
                    end
                    pace();
                    send_word(8'($urandom), 1'b1, (i == 0 && with_first) || i == restart_at,
                              (i == len - 1) && !invalid_end,
                              (i == restart_at) ? 32'($urandom) : sd);
                end
                if (invalid_end)
                begin
                    pace();
                    send_word(8'($urandom), 1'b0, 1'b0, 1'b1, $urandom);
                end
            end
        end
    endtask

    // Receiver stall pattern, switching between randomly chosen modes after runs of random length.
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = $urandom_range(3);
            stall_run  = $urandom_range(20, 300);
        end
        stall_run--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(3) == 0);
            2:       out_stall <= 1'($urandom_range(1));
            default: out_stall <= ($urandom_range(15) != 0);
        endcase
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_hash(hash_value);
    end

    // Watchdog on cycles where neither channel moves a word.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("murmur2a_byte_stream_hash32 verification failed");
            $finish;
        end
    end

    // Main sequence: reset, directed keys, random keys, drain.
    initial
    begin
        int len;
        tracker      = new();
        word_count   = 0;
        burst_left   = 0;
        stall_mode   = 0;
        stall_run    = 0;
        idle_cycles  = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        key_byte     = '0;
        byte_valid   = 1'b0;
        first_of_key = 1'b0;
        last_of_key  = 1'b0;
        seed         = '0;
        out_stall    = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Single byte with no first word: continues from the reset hash.
        send_word(8'hAB, 1'b1, 1'b0, 1'b1, 32'h0);
        // Empty keys with both extreme seeds.
        send_word(8'h00, 1'b0, 1'b1, 1'b1, 32'h0000_0000);
        send_word(8'hFF, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);
        // One full group of all-ones bytes.
        send_word(8'hFF, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF);
        send_word(8'hFF, 1'b1, 1'b0, 1'b0, 32'h0);
        send_word(8'hFF, 1'b1, 1'b0, 1'b0, 32'h0);
        send_word(8'hFF, 1'b1, 1'b0, 1'b1, 32'h0);
        // Seed load on an invalid byte, an ignored middle word, three-byte tail.
        send_word(8'h00, 1'b0, 1'b1, 1'b0, 32'h8000_0001);
        send_word(8'h00, 1'b1, 1'b0, 1'b0, 32'h0);
        send_word(8'h00, 1'b0, 1'b0, 1'b0, 32'h0);
        send_word(8'h80, 1'b1, 1'b0, 1'b0, 32'h0);
        send_word(8'h7F, 1'b1, 1'b0, 1'b1, 32'h0);
        // One-byte key with first and last together.
        send_word(8'h5A, 1'b1, 1'b1, 1'b1, 32'h1234_5678);
        // A new first in the middle of a key restarts it.
        send_word(8'h11, 1'b1, 1'b1, 1'b0, 32'hA5A5_A5A5);
        send_word(8'h22, 1'b1, 1'b0, 1'b0, 32'h0);
        send_word(8'h33, 1'b1, 1'b1, 1'b0, 32'h5A5A_5A5A);
        send_word(8'h44, 1'b1, 1'b0, 1'b0, 32'h0);
        send_word(8'h55, 1'b1, 1'b0, 1'b1, 32'h0);
        // Continuation from the previous hash, closed by a word without a byte.
        send_word(8'h01, 1'b1, 1'b0, 1'b0, 32'h0);
        send_word(8'h02, 1'b1, 1'b0, 1'b0, 32'h0);
        send_word(8'h03, 1'b0, 1'b0, 1'b1, 32'h0);

        // Random keys, mostly short and well formed.
        word_count = 0;
        while (word_count < RANDOM_WORDS)
        begin
            len = ($urandom_range(99) < 85) ? $urandom_range(0, 9) : $urandom_range(10, 40);
            send_key(len, ($urandom_range(15) == 0) ? 32'h0 : 32'($urandom),
                     $urandom_range(99));
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain: wait for every owed hash, then let the block settle.
        while (tracker.expected_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.expected_hashes.size() != 0)
            tracker.fails++;

        if (tracker.fails == 0)
            $display("murmur2a_byte_stream_hash32 verification clean");
        else
            $display("murmur2a_byte_stream_hash32 verification failed");
        $finish;
    end

endmodule

### sim.f
rtl/mm2a_pkg.sv
rtl/murmur2a_byte_stream_hash32.sv
tb/murmur2a_byte_stream_hash32_test.sv
